/* rtl/mm_pkg.sv */
// Shared types and constants for the MDIO management master.
// Used by every module of the block; depends on nothing.
package mm_pkg;

   localparam logic [1:0] MODE_TICK   = 2'd0;
   localparam logic [1:0] MODE_WRITE  = 2'd1;
   localparam logic [1:0] MODE_READ   = 2'd2;
   localparam logic [1:0] MODE_STATUS = 2'd3;

   localparam logic REG_HALF_PERIOD = 1'b0;
   localparam logic REG_ENABLE      = 1'b1;

   localparam logic [15:0] HALF_PERIOD_RESET = 16'd48;
   localparam logic [1:0]  OPCODE_READ       = 2'b10;
   localparam logic [4:0]  READ_RELEASE_BIT  = 5'd14;

   typedef struct packed {
      logic [1:0]  mode;
      logic [31:0] management_word;
      logic        mdio_in;
   } req_type;

   typedef struct packed {
      logic [31:0] read_data;
      logic        phy_idle;
      logic        mdc;
      logic        mdio_out;
      logic        mdio_oe;
   } rsp_type;

   typedef struct packed {
      logic [15:0] mdc_half_period;
      logic        mdio_enable;
   } cfg_type;

endpackage

/* rtl/mm_csr.sv */
// APB-style configuration registers of the MDIO management master.
// Depends on mm_pkg for the register indexes and the configuration struct.
module mm_csr (
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [2:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready,
   output mm_pkg::cfg_type   cfg
);

   logic [15:0] half_period_ff;
   logic [15:0] half_period_in;
   logic        enable_ff;
   logic        enable_in;
   logic        write_en;

   assign pready   = 1'b1;
   assign write_en = psel && penable && pwrite;

   always_comb begin
      half_period_in = half_period_ff;
      enable_in      = enable_ff;
      if (write_en) begin
         if (paddr[2] == mm_pkg::REG_HALF_PERIOD) begin
            half_period_in = pwdata[15:0];
         end else begin
            enable_in = pwdata[0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         half_period_ff <= mm_pkg::HALF_PERIOD_RESET;
         enable_ff      <= 1'b0;
      end else begin
         half_period_ff <= half_period_in;
         enable_ff      <= enable_in;
      end
   end

   always_comb begin
      if (paddr[2] == mm_pkg::REG_HALF_PERIOD) begin
         prdata = {16'd0, half_period_ff};
      end else begin
         prdata = {31'd0, enable_ff};
      end
   end

   assign cfg.mdc_half_period = half_period_ff;
   assign cfg.mdio_enable     = enable_ff;

endmodule

/* rtl/mm_core.sv */
// Frame state of the MDIO master: divider, shifter, bit counter and read capture.
// Updates on each accepted item and forms its result; depends on mm_pkg.
module mm_core #(
   parameter int PREAMBLE_BITS = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  mm_pkg::req_type   req,
   input  mm_pkg::cfg_type   cfg,
   output mm_pkg::rsp_type   rsp
);

   localparam logic [6:0] PRE_C   = 7'(PREAMBLE_BITS);
   localparam logic [6:0] FRAME_C = 7'(PREAMBLE_BITS + 32);

   logic [31:0] mgmt_ff, mgmt_in;
   logic [31:0] shift_ff, shift_in;
   logic [6:0]  bc_ff, bc_in;
   logic [15:0] div_ff, div_in;
   logic        mdc_ff, mdc_in;
   logic        busy_ff, busy_in;
   logic        read_ff, read_in;

   always_comb begin
      logic [15:0] div_inc;
      logic [15:0] hp;
      logic [6:0]  k;
      logic [6:0]  kn;
      logic [6:0]  bc_inc;
      logic [31:0] rd;
      logic        drv;
      logic        oe;

      mgmt_in  = mgmt_ff;
      shift_in = shift_ff;
      bc_in    = bc_ff;
      div_in   = div_ff;
      mdc_in   = mdc_ff;
      busy_in  = busy_ff;
      read_in  = read_ff;
      rd       = 32'd0;
      drv      = 1'b0;
      oe       = 1'b0;
      div_inc  = div_ff + 16'd1;
      hp       = (cfg.mdc_half_period == 16'd0) ? 16'd1 : cfg.mdc_half_period;
      k        = bc_ff - PRE_C;
      bc_inc   = bc_ff + 7'd1;

      if (accept) begin
         case (req.mode)
            mm_pkg::MODE_TICK: begin
               if (div_inc >= hp) begin
                  div_in = 16'd0;
                  mdc_in = ~mdc_ff;
                  if (!mdc_ff) begin
                     if (busy_ff && read_ff && bc_ff >= PRE_C && k inside {[16:31]}) begin
                        mgmt_in[5'd31 - k[4:0]] = req.mdio_in;
                     end
                  end else if (busy_ff) begin
                     if (bc_ff >= PRE_C) begin
                        shift_in = {shift_ff[30:0], 1'b0};
                     end
                     if (bc_inc >= FRAME_C) begin
                        busy_in = 1'b0;
                        bc_in   = 7'd0;
                     end else begin
                        bc_in = bc_inc;
                     end
                  end
               end else begin
                  div_in = div_inc;
               end
            end
            mm_pkg::MODE_WRITE: begin
               if (cfg.mdio_enable && !busy_ff) begin
                  mgmt_in  = req.management_word;
                  shift_in = req.management_word;
                  bc_in    = 7'd0;
                  div_in   = 16'd0;
                  mdc_in   = 1'b0;
                  busy_in  = 1'b1;
                  read_in  = (req.management_word[29:28] == mm_pkg::OPCODE_READ);
               end
            end
            mm_pkg::MODE_READ: begin
               rd = mgmt_ff;
            end
            default: begin
               rd = {31'd0, ~busy_ff};
            end
         endcase
      end

      kn = bc_in - PRE_C;
      if (busy_in) begin
         if (bc_in < PRE_C) begin
            drv = 1'b1;
            oe  = 1'b1;
         end else if (!(read_in && kn >= {2'b00, mm_pkg::READ_RELEASE_BIT})) begin
            drv = shift_in[31];
            oe  = 1'b1;
         end
      end

      rsp.read_data = rd;
      rsp.phy_idle  = ~busy_in;
      rsp.mdc       = mdc_in;
      rsp.mdio_out  = drv;
      rsp.mdio_oe   = oe;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mgmt_ff  <= 32'd0;
         shift_ff <= 32'd0;
         bc_ff    <= 7'd0;
         div_ff   <= 16'd0;
         mdc_ff   <= 1'b0;
         busy_ff  <= 1'b0;
         read_ff  <= 1'b0;
      end else begin
         mgmt_ff  <= mgmt_in;
         shift_ff <= shift_in;
         bc_ff    <= bc_in;
         div_ff   <= div_in;
         mdc_ff   <= mdc_in;
         busy_ff  <= busy_in;
         read_ff  <= read_in;
      end
   end

endmodule

/* rtl/mm_skid.sv */
// Result register with a skid stage for the MDIO management master.
// Holds results while the receiver stalls; depends on mm_pkg for the result struct.
module mm_skid (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_stall,
   input  mm_pkg::rsp_type   in_data,
   output logic              out_valid,
   input  logic              out_stall,
   output mm_pkg::rsp_type   out_data
);

   mm_pkg::rsp_type out_ff, out_in;
   mm_pkg::rsp_type skid_ff, skid_in;
   logic            out_valid_ff, out_valid_in;
   logic            skid_valid_ff, skid_valid_in;
   logic            accept;
   logic            take;

   assign in_stall  = skid_valid_ff;
   assign accept    = in_valid && !skid_valid_ff;
   assign take      = out_valid_ff && !out_stall;
   assign out_valid = out_valid_ff;
   assign out_data  = out_ff;

   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (!out_valid_ff || take) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            out_in       = in_data;
            out_valid_in = accept;
         end
      end else if (accept) begin
         skid_in       = in_data;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

endmodule

/* rtl/mdio_management_master.sv */
// Top level of the MDIO clause-22 management master.
// Instantiates mm_csr, mm_core and mm_skid; depends on mm_pkg.
//
// Each input item on the req_ channel is a clock tick, a write or read of the
// management word, or a status read. An item is taken when req_valid is high
// and req_stall is low, and exactly one result item follows on the rsp_
// channel, carrying read data, the idle flag and the MDC and MDIO line levels
// as they stand after the item.
// One item is accepted in every cycle in which req_stall is low; the frame
// state updates in a single pass of logic set by the 16-bit divider add and
// compare. A result register and a one-entry skid stage sit on the output, so
// an item is still accepted while a result waits; req_stall rises only when
// both are full and falls once the receiver takes a result. Reset clears the
// frame state, the divider and both output entries, sets the half period to
// 48 ticks and disables the port. The user must write the half period and
// enable registers over the APB-style port only while the block is idle; the
// block itself does not enforce this.
module mdio_management_master #(
   parameter int PREAMBLE_BITS = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  mm_pkg::req_type   req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output mm_pkg::rsp_type   rsp_payload,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [2:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);

   mm_pkg::cfg_type cfg;
   mm_pkg::rsp_type core_rsp;
   logic            accept;

   assign accept = req_valid && !req_stall;

   mm_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   mm_core #(
      .PREAMBLE_BITS (PREAMBLE_BITS)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req    (req_payload),
      .cfg    (cfg),
      .rsp    (core_rsp)
   );

   mm_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_stall  (req_stall),
      .in_data   (core_rsp),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (rsp_payload)
   );

endmodule

/* rtl/mm_checker.sv */
// Port-level checks for the MDIO management master, bound to the top level.
// Depends on mm_pkg for the payload structs.
module mm_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input mm_pkg::rsp_type   rsp_payload
);

   a_reset_empty : assert property (@(posedge clock) !reset && $past(reset) |-> !rsp_valid)
      else $error("result present straight after reset");

   a_stall_needs_result : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("input stalled with no result waiting");

   a_result_held : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled result changed");

   a_idle_no_drive : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.phy_idle |-> !rsp_payload.mdio_oe && !rsp_payload.mdio_out)
      else $error("line driven while idle");

endmodule

bind mdio_management_master mm_checker u_mm_checker (
   .clock       (clock),
   .reset       (reset),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);

/* bench/mdio_management_master_test.sv */
// Self-checking bench for the MDIO management master: drives items, CSR writes and
// receiver stalls, and checks every result against an in-bench frame predictor.
// Depends on mm_pkg and the mdio_management_master top level.
module mdio_management_master_test;

   localparam int PREAMBLE_BITS = 32;
   localparam int FRAME_BITS    = PREAMBLE_BITS + 32;
   localparam int ITEM_TARGET   = 1150;
   localparam int DRAIN_CYCLES  = 4;
   localparam int CYCLE_LIMIT   = 600000;

   class mdio_frame_scoreboard;
      logic [15:0]     half_period;
      logic            port_enable;
      logic [31:0]     mgmt_word;
      logic [31:0]     shift_word;
      logic [6:0]      bits_done;
      logic [15:0]     divider;
      logic            mdc_level;
      logic            frame_busy;
      logic            frame_is_read;
      mm_pkg::rsp_type pending_line_states[$];
      int              errors;

      function new();
         half_period   = mm_pkg::HALF_PERIOD_RESET;
         port_enable   = 1'b0;
         mgmt_word     = '0;
         shift_word    = '0;
         bits_done     = '0;
         divider       = '0;
         mdc_level     = 1'b0;
         frame_busy    = 1'b0;
         frame_is_read = 1'b0;
         errors        = 0;
      endfunction

      function void set_register(logic reg_index, logic [31:0] value);
         if (reg_index == mm_pkg::REG_HALF_PERIOD) begin
            half_period = value[15:0];
         end else begin
            port_enable = value[0];
         end
      endfunction

      function void advance_divider(logic din);
         logic [15:0] limit;
         int          k;
         limit = (half_period == 16'd0) ? 16'd1 : half_period;
         divider = divider + 16'd1;
         if (divider < limit) return;
         divider = '0;
         mdc_level = !mdc_level;
         if (!frame_busy) return;
         k = int'(bits_done) - PREAMBLE_BITS;
         if (mdc_level) begin
            if (frame_is_read && k >= 16 && k <= 31) mgmt_word[31 - k] = din;
         end else begin
            if (k >= 0) shift_word = shift_word << 1;
            bits_done = bits_done + 7'd1;
            if (int'(bits_done) >= FRAME_BITS) begin
               frame_busy = 1'b0;
               bits_done  = '0;
            end
         end
      endfunction

      function void predict_item(mm_pkg::req_type item);
         mm_pkg::rsp_type want;
         int              k;
         want = '0;
         case (item.mode)
            mm_pkg::MODE_TICK: begin
               advance_divider(item.mdio_in);
            end
            mm_pkg::MODE_WRITE: begin
               if (port_enable && !frame_busy) begin
                  mgmt_word     = item.management_word;
                  shift_word    = item.management_word;
                  bits_done     = '0;
                  divider       = '0;
                  mdc_level     = 1'b0;
                  frame_busy    = 1'b1;
                  frame_is_read = (item.management_word[29:28] == mm_pkg::OPCODE_READ);
               end
            end
            mm_pkg::MODE_READ: begin
               want.read_data = mgmt_word;
            end
            default: begin
               want.read_data = {31'd0, !frame_busy};
            end
         endcase
         want.phy_idle = !frame_busy;
         want.mdc      = mdc_level;
         if (frame_busy) begin
            k = int'(bits_done) - PREAMBLE_BITS;
            if (k < 0) begin
               want.mdio_out = 1'b1;
               want.mdio_oe  = 1'b1;
            end else if (!(frame_is_read && k >= int'(mm_pkg::READ_RELEASE_BIT))) begin
               want.mdio_out = shift_word[31];
               want.mdio_oe  = 1'b1;
            end
         end
         pending_line_states.push_back(want);
      endfunction

      function void compare_field(string field, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $error("%s: expected %h, got %h", field, want, got);
            errors++;
         end
      endfunction

      function void compare_result(mm_pkg::rsp_type got);
         mm_pkg::rsp_type want;
         if (pending_line_states.size() == 0) begin
            $error("result item arrived with nothing expected");
            errors++;
            return;
         end
         want = pending_line_states.pop_front();
         compare_field("read_data", want.read_data, got.read_data);
         compare_field("phy_idle", 32'(want.phy_idle), 32'(got.phy_idle));
         compare_field("mdc", 32'(want.mdc), 32'(got.mdc));
         compare_field("mdio_out", 32'(want.mdio_out), 32'(got.mdio_out));
         compare_field("mdio_oe", 32'(want.mdio_oe), 32'(got.mdio_oe));
      endfunction
   endclass

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_stall;
   mm_pkg::req_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_stall = 1'b0;
   mm_pkg::rsp_type rsp_payload;
   logic            psel = 1'b0;
   logic            penable = 1'b0;
   logic            pwrite = 1'b0;
   logic [2:0]      paddr = '0;
   logic [31:0]     pwdata = '0;
   logic [31:0]     prdata;
   logic            pready;

   mdio_frame_scoreboard sb = new();
   int items_sent = 0;
   int cycle_count = 0;
   int stall_left = 0;
   bit quiet = 1'b0;
   bit calm = 1'b0;

   mdio_management_master u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.compare_result(rsp_payload);
   end

   always @(negedge clock) begin
      int pick;
      pick = $urandom_range(0, 99);
      if (reset || calm) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else if (pick < 70) begin
         rsp_stall <= 1'b0;
      end else if (pick < 97) begin
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b1;
         stall_left = $urandom_range(5, 30);
      end
   end

   function automatic int pick_gap();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 70) return 0;
      if (pick < 95) return $urandom_range(1, 3);
      return $urandom_range(5, 25);
   endfunction

   task automatic send_item(input logic [1:0] mode, input logic [31:0] word,
                            input logic din);
      mm_pkg::req_type item;
      int              gap;
      item.mode            = mode;
      item.management_word = word;
      item.mdio_in         = din;
      gap = quiet ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.predict_item(item);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (sb.pending_line_states.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic csr_write(input logic reg_index, input logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {reg_index, 2'b00};
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      sb.set_register(reg_index, value);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
   endtask

   task automatic run_ticks(input int count);
      repeat (count) send_item(mm_pkg::MODE_TICK, $urandom, 1'($urandom_range(0, 1)));
   endtask

   task automatic run_frame_sequence(input int ticks_per_half, input bit broken);
      logic [31:0] word;
      int          tick_total;
      int          pick;
      word = $urandom;
      if ($urandom_range(0, 1)) word[29:28] = mm_pkg::OPCODE_READ;
      send_item(mm_pkg::MODE_WRITE, word, 1'($urandom_range(0, 1)));
      tick_total = broken ? $urandom_range(1, 64 * ticks_per_half)
                          : 128 * ticks_per_half + $urandom_range(1, 4);
      while (tick_total > 0) begin
         pick = $urandom_range(0, 99);
         if (pick < 90) begin
            send_item(mm_pkg::MODE_TICK, $urandom, 1'($urandom_range(0, 1)));
            tick_total--;
         end else if (pick < 94) begin
            send_item(mm_pkg::MODE_READ, $urandom, 1'($urandom_range(0, 1)));
         end else if (pick < 98) begin
            send_item(mm_pkg::MODE_STATUS, $urandom, 1'($urandom_range(0, 1)));
         end else begin
            send_item(mm_pkg::MODE_WRITE, $urandom, 1'($urandom_range(0, 1)));
         end
      end
   endtask

   initial begin
      int half_ticks;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Out of reset the port is disabled, so the write is dropped.
      send_item(mm_pkg::MODE_STATUS, 32'h0, 1'b0);
      send_item(mm_pkg::MODE_WRITE, 32'hFFFF_FFFF, 1'b1);
      send_item(mm_pkg::MODE_READ, 32'h0, 1'b1);
      send_item(mm_pkg::MODE_TICK, 32'hFFFF_FFFF, 1'b1);
      send_item(mm_pkg::MODE_TICK, 32'h0, 1'b0);
      settle();

      // A zero half period behaves as one; the second write lands while busy.
      csr_write(mm_pkg::REG_HALF_PERIOD, 32'd0);
      csr_write(mm_pkg::REG_ENABLE, 32'd1);
      send_item(mm_pkg::MODE_WRITE, 32'h6002_0000, 1'b0);
      send_item(mm_pkg::MODE_WRITE, 32'h5002_0000, 1'b1);
      send_item(mm_pkg::MODE_STATUS, 32'h0, 1'b0);
      send_item(mm_pkg::MODE_READ, 32'h0, 1'b1);
      run_ticks(6);
      settle();

      // Disabling mid-frame must not cut the frame short.
      csr_write(mm_pkg::REG_ENABLE, 32'd0);
      run_ticks(130);
      send_item(mm_pkg::MODE_WRITE, $urandom, 1'b1);
      send_item(mm_pkg::MODE_STATUS, 32'h0, 1'b0);
      settle();

      // Largest half period, then a smaller one below the running count.
      csr_write(mm_pkg::REG_HALF_PERIOD, 32'h0000_FFFF);
      csr_write(mm_pkg::REG_ENABLE, 32'd1);
      send_item(mm_pkg::MODE_WRITE, 32'h5002_0000, 1'b0);
      run_ticks(10);
      settle();
      csr_write(mm_pkg::REG_HALF_PERIOD, 32'd3);
      run_ticks(128 * 3);

      while (items_sent < ITEM_TARGET) begin
         settle();
         case ($urandom_range(0, 5))
            0: half_ticks = 0;
            1, 2, 3: half_ticks = 1;
            4: half_ticks = 2;
            default: half_ticks = 3;
         endcase
         csr_write(mm_pkg::REG_HALF_PERIOD, half_ticks);
         csr_write(mm_pkg::REG_ENABLE, 32'($urandom_range(0, 9) != 0));
         quiet = ($urandom_range(0, 3) == 0);
         calm  = ($urandom_range(0, 3) == 0);
         repeat ($urandom_range(1, 3)) begin
            run_frame_sequence((half_ticks == 0) ? 1 : half_ticks,
                               ($urandom_range(0, 6) == 0));
         end
      end
      settle();

      if (sb.errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
